// ----- rtl/core/servo_gate_pot_calibrator_defines.svh -----
// Assertion macros used by the bound checker, sgpc_checker.
`ifndef SERVO_GATE_POT_CALIBRATOR_DEFINES_SVH
`define SERVO_GATE_POT_CALIBRATOR_DEFINES_SVH

// Check a property at every rising clock edge outside reset.
`define SGPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// Check that a signal holds while its channel stalls.
`define SGPC_ASSERT_HOLD(lbl, clk, rst, vld, rdy, sig) \
   lbl: assert property (@(posedge clk) disable iff (rst) ((vld) && !(rdy) |=> $stable(sig))) \
      else $error("%m: value changed during stall");

`endif

// ----- rtl/core/sgpc_pkg.sv -----
`default_nettype none
package sgpc_pkg;

   localparam int ReadW     = 10;
   localparam int AngleW    = 8;
   localparam int CountW    = 16;
   localparam int ActionW   = 3;
   localparam int EventW    = 2;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 16;

   localparam int ReadFull  = 1023;
   localparam int AngleFull = 180;
   localparam int ProdW     = 18;

   // Action codes
   localparam logic [ActionW-1:0] ACT_SAMPLE = 3'd0;
   localparam logic [ActionW-1:0] ACT_OPEN   = 3'd1;
   localparam logic [ActionW-1:0] ACT_CLOSE  = 3'd2;
   localparam logic [ActionW-1:0] ACT_STEP   = 3'd3;
   localparam logic [ActionW-1:0] ACT_INIT   = 3'd4;

   // Calibration event codes
   localparam logic [EventW-1:0] EVT_NONE = 2'd0;
   localparam logic [EventW-1:0] EVT_MOVE = 2'd1;
   localparam logic [EventW-1:0] EVT_DONE = 2'd2;

   // Register indexes
   localparam logic [CsrIndexW-1:0] CSR_BEGIN_THRESHOLD = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_FLOAT_THRESHOLD = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_CALIB_TIMEOUT   = 2'd2;

   localparam logic [ReadW-1:0]  BeginReset   = 10'd17;
   localparam logic [ReadW-1:0]  FloatReset   = 10'd5;
   localparam logic [CountW-1:0] TimeoutReset = 16'd30;

   typedef struct packed {
      logic [ActionW-1:0] action;
      logic [ReadW-1:0]   open_pot_reading;
      logic [ReadW-1:0]   closed_pot_reading;
   } sgpc_req_type;

   typedef struct packed {
      logic [AngleW-1:0] servo_angle;
      logic              at_target;
      logic              gate_is_open;
      logic              open_calibrating;
      logic              closed_calibrating;
      logic [EventW-1:0] calib_event;
   } sgpc_rsp_type;

   typedef struct packed {
      logic [ReadW-1:0]  begin_threshold;
      logic [ReadW-1:0]  float_threshold;
      logic [CountW-1:0] calib_timeout_samples;
   } sgpc_cfg_type;

   // reading * 180 / 1023: divide by 1024, then one correction step since
   // the remainder stays below twice the divisor.
   function automatic logic [AngleW-1:0] to_angle(input logic [ReadW-1:0] r);
      logic [ProdW-1:0]  prod;
      logic [AngleW-1:0] q0;
      logic [ReadW:0]    rem;
      prod = ProdW'(r) * ProdW'(AngleFull);
      q0   = prod[ProdW-1:ReadW];
      rem  = (ReadW+1)'(prod[ReadW-1:0]) + (ReadW+1)'(q0);
      return q0 + AngleW'(rem >= (ReadW+1)'(ReadFull));
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sgpc_csr.sv -----
`default_nettype none
module sgpc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sgpc_pkg::CsrIndexW-1:0]  csr_index,
   input  wire logic [sgpc_pkg::CsrDataW-1:0]   csr_data,
   output sgpc_pkg::sgpc_cfg_type               cfg
);
   import sgpc_pkg::*;

   sgpc_cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begin_threshold       <= BeginReset;
         cfg_ff.float_threshold       <= FloatReset;
         cfg_ff.calib_timeout_samples <= TimeoutReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BEGIN_THRESHOLD: cfg_ff.begin_threshold <= csr_data[ReadW-1:0];
            CSR_FLOAT_THRESHOLD: cfg_ff.float_threshold <= csr_data[ReadW-1:0];
            CSR_CALIB_TIMEOUT:   cfg_ff.calib_timeout_samples <= csr_data[CountW-1:0];
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/sgpc_core.sv -----
`default_nettype none
module sgpc_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  sgpc_pkg::sgpc_cfg_type      cfg,
   input  sgpc_pkg::sgpc_req_type      item,
   output sgpc_pkg::sgpc_rsp_type      result
);
   import sgpc_pkg::*;

   logic [ReadW-1:0]  open_reading_ff, open_reading_in;
   logic [ReadW-1:0]  closed_reading_ff, closed_reading_in;
   logic              open_cal_ff, open_cal_in;
   logic              closed_cal_ff, closed_cal_in;
   logic              gate_open_ff, gate_open_in;
   logic [AngleW-1:0] current_ff, current_in;
   logic [AngleW-1:0] target_ff, target_in;
   logic [CountW-1:0] quiet_ff, quiet_in;

   logic [ReadW-1:0]  open_diff, closed_diff;
   logic              open_move, closed_move;
   logic [CountW-1:0] quiet_inc;
   logic              quiet_done;
   logic              retarget, load_current;
   logic [ReadW-1:0]  tgt_src;
   logic [AngleW-1:0] src_angle;
   logic [EventW-1:0] evt;

   assign open_diff = (item.open_pot_reading >= open_reading_ff)
                    ? item.open_pot_reading - open_reading_ff
                    : open_reading_ff - item.open_pot_reading;
   assign closed_diff = (item.closed_pot_reading >= closed_reading_ff)
                      ? item.closed_pot_reading - closed_reading_ff
                      : closed_reading_ff - item.closed_pot_reading;

   assign open_move = open_cal_ff ? (open_diff >= cfg.float_threshold)
                                  : (open_diff >= cfg.begin_threshold);
   assign closed_move = closed_cal_ff ? (closed_diff >= cfg.float_threshold)
                                      : (closed_diff >= cfg.begin_threshold);

   // saturate the quiet count
   assign quiet_inc  = (&quiet_ff) ? quiet_ff : quiet_ff + CountW'(1);
   assign quiet_done = quiet_inc >= cfg.calib_timeout_samples;

   always_comb begin
      open_reading_in   = open_reading_ff;
      closed_reading_in = closed_reading_ff;
      open_cal_in       = open_cal_ff;
      closed_cal_in     = closed_cal_ff;
      gate_open_in      = gate_open_ff;
      current_in        = current_ff;
      target_in         = target_ff;
      quiet_in          = quiet_ff;
      retarget          = 1'b0;
      load_current      = 1'b0;
      tgt_src           = open_reading_ff;
      evt               = EVT_NONE;

      unique case (item.action)
         ACT_SAMPLE: begin
            priority if (open_cal_ff) begin
               if (open_move) begin
                  open_reading_in = item.open_pot_reading;
                  quiet_in        = '0;
                  retarget        = 1'b1;
                  tgt_src         = item.open_pot_reading;
                  evt             = EVT_MOVE;
               end else begin
                  quiet_in = quiet_inc;
                  if (quiet_done) begin
                     open_cal_in = 1'b0;
                     retarget    = 1'b1;
                     tgt_src     = gate_open_ff ? open_reading_ff : closed_reading_ff;
                     evt         = EVT_DONE;
                  end
               end
            end else if (closed_cal_ff) begin
               if (closed_move) begin
                  closed_reading_in = item.closed_pot_reading;
                  quiet_in          = '0;
                  retarget          = 1'b1;
                  tgt_src           = item.closed_pot_reading;
                  evt               = EVT_MOVE;
               end else begin
                  quiet_in = quiet_inc;
                  if (quiet_done) begin
                     closed_cal_in = 1'b0;
                     retarget      = 1'b1;
                     tgt_src       = gate_open_ff ? open_reading_ff : closed_reading_ff;
                     evt           = EVT_DONE;
                  end
               end
            end else if (open_move) begin
               open_cal_in     = 1'b1;
               open_reading_in = item.open_pot_reading;
               quiet_in        = '0;
               retarget        = 1'b1;
               tgt_src         = item.open_pot_reading;
               evt             = EVT_MOVE;
            end else if (closed_move) begin
               closed_cal_in     = 1'b1;
               closed_reading_in = item.closed_pot_reading;
               quiet_in          = '0;
               retarget          = 1'b1;
               tgt_src           = item.closed_pot_reading;
               evt               = EVT_MOVE;
            end else begin
               // neither pot moved and none calibrates: hold state
               evt = EVT_NONE;
            end
         end
         ACT_OPEN: begin
            if (!gate_open_ff) begin
               gate_open_in = 1'b1;
               retarget     = !open_cal_ff && !closed_cal_ff;
               tgt_src      = open_reading_ff;
            end
         end
         ACT_CLOSE: begin
            if (gate_open_ff) begin
               gate_open_in = 1'b0;
               retarget     = !open_cal_ff && !closed_cal_ff;
               tgt_src      = closed_reading_ff;
            end
         end
         ACT_STEP: begin
            priority if (current_ff < target_ff) current_in = current_ff + AngleW'(1);
            else if (current_ff > target_ff)     current_in = current_ff - AngleW'(1);
            else                                 current_in = current_ff;
         end
         ACT_INIT: begin
            open_reading_in   = item.open_pot_reading;
            closed_reading_in = item.closed_pot_reading;
            gate_open_in      = 1'b0;
            open_cal_in       = 1'b0;
            closed_cal_in     = 1'b0;
            quiet_in          = '0;
            retarget          = 1'b1;
            load_current      = 1'b1;
            tgt_src           = item.closed_pot_reading;
         end
         default: ;
      endcase

      src_angle = to_angle(tgt_src);
      if (retarget)     target_in  = src_angle;
      if (load_current) current_in = src_angle;
   end

   assign result.servo_angle        = current_in;
   assign result.at_target          = current_in == target_in;
   assign result.gate_is_open       = gate_open_in;
   assign result.open_calibrating   = open_cal_in;
   assign result.closed_calibrating = closed_cal_in;
   assign result.calib_event        = evt;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_reading_ff   <= '0;
         closed_reading_ff <= '0;
         open_cal_ff       <= 1'b0;
         closed_cal_ff     <= 1'b0;
         gate_open_ff      <= 1'b0;
         current_ff        <= '0;
         target_ff         <= '0;
         quiet_ff          <= '0;
      end else if (advance) begin
         open_reading_ff   <= open_reading_in;
         closed_reading_ff <= closed_reading_in;
         open_cal_ff       <= open_cal_in;
         closed_cal_ff     <= closed_cal_in;
         gate_open_ff      <= gate_open_in;
         current_ff        <= current_in;
         target_ff         <= target_in;
         quiet_ff          <= quiet_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/servo_gate_pot_calibrator.sv -----
// A beat accepted into the input register moves through the update logic into
// the result register and shows up on rsp_. One beat per clock while rsp_ready
// holds; the two-register pipeline stalls when the result register is held full.
// Reset (synchronous, active high): empties both registers, clears gate, angle,
// calibration and quiet state, and loads the register defaults 17, 5 and 30.
`default_nettype none
module servo_gate_pot_calibrator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  sgpc_pkg::sgpc_req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output sgpc_pkg::sgpc_rsp_type               rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sgpc_pkg::CsrIndexW-1:0]  csr_index,
   input  wire logic [sgpc_pkg::CsrDataW-1:0]   csr_data
);
   import sgpc_pkg::*;

   sgpc_cfg_type cfg;
   sgpc_req_type req_data_ff;
   sgpc_rsp_type rsp_data_ff, rsp_data_in;
   logic         req_valid_ff;
   logic         rsp_valid_ff;
   logic         advance;

   // Advance the held beat into the result register when that register is
   // empty or is being drained this cycle; the core state moves with it, so
   // the next beat always sees the state the previous one left.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   // Take a new beat whenever the input register frees up.
   assign req_ready = !req_valid_ff || advance;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sgpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sgpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .item    (req_data_ff),
      .result  (rsp_data_in)
   );

   // Hold control under reset; payload registers load only on a handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready)                 req_valid_ff <= req_valid;
         if (advance)                   rsp_valid_ff <= 1'b1;
         else if (rsp_ready)            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) req_data_ff <= req_data;
      if (advance)                rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ----- rtl/core/sgpc_checker.sv -----
`default_nettype none
`include "servo_gate_pot_calibrator_defines.svh"
module sgpc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input sgpc_pkg::sgpc_req_type               req_data,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input sgpc_pkg::sgpc_rsp_type               rsp_data,
   input wire logic                            csr_valid,
   input wire logic                            csr_ready,
   input wire logic [sgpc_pkg::CsrIndexW-1:0]  csr_index,
   input wire logic [sgpc_pkg::CsrDataW-1:0]   csr_data
);
   import sgpc_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_valid, req_ready, req_data, csr_valid, csr_ready,
                        csr_index, csr_data};

   `SGPC_ASSERT(rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `SGPC_ASSERT_HOLD(rsp_data_holds, clock, reset, rsp_valid, rsp_ready, rsp_data)
   `SGPC_ASSERT(angle_in_range, clock, reset, rsp_valid |-> rsp_data.servo_angle <= 8'd180)
   `SGPC_ASSERT(one_pot_calibrates, clock, reset, rsp_valid |-> !(rsp_data.open_calibrating && rsp_data.closed_calibrating))
   `SGPC_ASSERT(done_clears_flags, clock, reset, rsp_valid && rsp_data.calib_event == EVT_DONE |-> !rsp_data.open_calibrating && !rsp_data.closed_calibrating)

endmodule

bind servo_gate_pot_calibrator sgpc_checker u_sgpc_checker (.*);
`default_nettype wire

// ----- verif/sgpc_gate_checker.sv -----
`timescale 1ns / 100ps
module sgpc_gate_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  sgpc_pkg::sgpc_req_type          req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  sgpc_pkg::sgpc_rsp_type          rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [sgpc_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [sgpc_pkg::CsrDataW-1:0]   csr_data,
   output int                              error_count,
   output int                              pending,
   output int                              checked_count,
   output int                              move_count,
   output int                              done_count
);
   import sgpc_pkg::*;

   // Shadow copy of the registers
   logic [ReadW-1:0]  thr_begin;
   logic [ReadW-1:0]  thr_float;
   logic [CountW-1:0] timeout_len;

   // Shadow copy of the gate state
   logic [ReadW-1:0]  stored_open;
   logic [ReadW-1:0]  stored_closed;
   logic              cal_open;
   logic              cal_closed;
   logic              gate_open;
   logic [AngleW-1:0] servo_pos;
   logic [AngleW-1:0] servo_goal;
   logic [CountW-1:0] quiet_samples;

   sgpc_rsp_type expected_status[$];

   function automatic logic [AngleW-1:0] reading_to_degrees(input logic [ReadW-1:0] r);
      return AngleW'((int'(r) * AngleFull) / ReadFull);
   endfunction

   // Compare one pot against its stored reading; movement retargets the servo.
   task automatic probe_pot(input logic [ReadW-1:0] now, inout logic [ReadW-1:0] held,
                            inout logic calib, output logic [EventW-1:0] evt);
      logic [ReadW-1:0] delta;
      delta = (now >= held) ? now - held : held - now;
      evt   = EVT_NONE;
      if ((!calib && delta >= thr_begin) || (calib && delta >= thr_float)) begin
         calib         = 1'b1;
         quiet_samples = '0;
         held          = now;
         servo_goal    = reading_to_degrees(now);
         evt           = EVT_MOVE;
      end else if (calib) begin
         if (quiet_samples != '1)
            quiet_samples = quiet_samples + 1'b1;
         if (quiet_samples >= timeout_len) begin
            calib = 1'b0;
            evt   = EVT_DONE;
         end
      end
   endtask

   task automatic advance_gate(input sgpc_req_type item, output sgpc_rsp_type res);
      logic [EventW-1:0] evt;
      evt = EVT_NONE;
      case (item.action)
         ACT_SAMPLE: begin
            if (cal_open) begin
               probe_pot(item.open_pot_reading, stored_open, cal_open, evt);
            end else if (cal_closed) begin
               probe_pot(item.closed_pot_reading, stored_closed, cal_closed, evt);
            end else begin
               probe_pot(item.open_pot_reading, stored_open, cal_open, evt);
               if (evt != EVT_MOVE)
                  probe_pot(item.closed_pot_reading, stored_closed, cal_closed, evt);
            end
            if (evt == EVT_DONE)
               servo_goal = reading_to_degrees(gate_open ? stored_open : stored_closed);
         end
         ACT_OPEN: begin
            if (!gate_open) begin
               gate_open = 1'b1;
               if (!cal_open && !cal_closed)
                  servo_goal = reading_to_degrees(stored_open);
            end
         end
         ACT_CLOSE: begin
            if (gate_open) begin
               gate_open = 1'b0;
               if (!cal_open && !cal_closed)
                  servo_goal = reading_to_degrees(stored_closed);
            end
         end
         ACT_STEP: begin
            if (servo_pos < servo_goal)
               servo_pos = servo_pos + 1'b1;
            else if (servo_pos > servo_goal)
               servo_pos = servo_pos - 1'b1;
         end
         ACT_INIT: begin
            stored_open   = item.open_pot_reading;
            stored_closed = item.closed_pot_reading;
            gate_open     = 1'b0;
            cal_open      = 1'b0;
            cal_closed    = 1'b0;
            quiet_samples = '0;
            servo_goal    = reading_to_degrees(item.closed_pot_reading);
            servo_pos     = servo_goal;
         end
         default: ;
      endcase
      res.servo_angle        = servo_pos;
      res.at_target          = (servo_pos == servo_goal);
      res.gate_is_open       = gate_open;
      res.open_calibrating   = cal_open;
      res.closed_calibrating = cal_closed;
      res.calib_event        = evt;
   endtask

   task automatic match_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      sgpc_rsp_type want;
      if (reset) begin
         thr_begin     <= BeginReset;
         thr_float     <= FloatReset;
         timeout_len   <= TimeoutReset;
         stored_open   = '0;
         stored_closed = '0;
         cal_open      = 1'b0;
         cal_closed    = 1'b0;
         gate_open     = 1'b0;
         servo_pos     = '0;
         servo_goal    = '0;
         quiet_samples = '0;
         expected_status.delete();
         error_count   = 0;
         checked_count = 0;
         move_count    = 0;
         done_count    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BEGIN_THRESHOLD: thr_begin   <= csr_data[ReadW-1:0];
               CSR_FLOAT_THRESHOLD: thr_float   <= csr_data[ReadW-1:0];
               CSR_CALIB_TIMEOUT:   timeout_len <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               error_count++;
               $display("%0t: result beat with nothing expected, actual %h", $time, rsp_data);
            end else begin
               want = expected_status.pop_front();
               checked_count++;
               match_field("servo_angle", want.servo_angle, rsp_data.servo_angle);
               match_field("at_target", want.at_target, rsp_data.at_target);
               match_field("gate_is_open", want.gate_is_open, rsp_data.gate_is_open);
               match_field("open_calibrating", want.open_calibrating,
                           rsp_data.open_calibrating);
               match_field("closed_calibrating", want.closed_calibrating,
                           rsp_data.closed_calibrating);
               match_field("calib_event", want.calib_event, rsp_data.calib_event);
            end
         end
         if (req_valid && req_ready) begin
            advance_gate(req_data, want);
            if (want.calib_event == EVT_MOVE)
               move_count++;
            if (want.calib_event == EVT_DONE)
               done_count++;
            expected_status.push_back(want);
         end
      end
      pending = expected_status.size();
   end

endmodule

// ----- verif/tb_servo_gate_pot_calibrator.sv -----
`timescale 1ns / 100ps
module tb_servo_gate_pot_calibrator;
   import sgpc_pkg::*;

   // Receiver hold-off length, long enough to fill the two-register pipeline.
   localparam int HOLD_CYCLES = 60;
   // Watchdog limit on the length of the run.
   localparam int CYCLE_LIMIT = 300000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   sgpc_req_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   sgpc_rsp_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index = CSR_BEGIN_THRESHOLD;
   logic [CsrDataW-1:0]  csr_data = '0;

   int fail_count;
   int pending;
   int checked_count;
   int move_count;
   int done_count;
   int cycle_count = 0;
   int beats_sent = 0;
   int settings_used = 0;

   // Idle controls for the sender and receiver processes, set by the stimulus.
   bit send_idles = 1'b0;
   bit take_idles = 1'b0;
   bit hold_go = 1'b0;

   // Simulated knob positions that the sample beats wobble around.
   int knob_open = 0;
   int knob_closed = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   servo_gate_pot_calibrator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   sgpc_gate_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .move_count    (move_count),
      .done_count    (done_count)
   );

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("servo_gate_pot_calibrator verification failed");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   // Each branch makes at most one assignment to rsp_ready per edge.
   initial begin : result_side
      int held;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_ready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
            rsp_ready <= 1'b1;
         end else if (take_idles && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one beat and hold it until accepted. Valid is left high so that a
   // following beat goes out back to back; a gap burst lowers it first.
   task automatic put_item(input logic [ActionW-1:0] act, input logic [ReadW-1:0] op,
                           input logic [ReadW-1:0] cl);
      sgpc_req_type item;
      item.action             = act;
      item.open_pot_reading   = op;
      item.closed_pot_reading = cl;
      if (send_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      beats_sent++;
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CsrIndexW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // Write all three registers; threshold writes carry random upper bits,
   // which the block must drop.
   task automatic set_regs(input int thr_begin, input int thr_float, input int timeout_len);
      logic [CsrDataW-1:0] data;
      data = CsrDataW'($urandom);
      data[ReadW-1:0] = ReadW'(thr_begin);
      csr_put(CSR_BEGIN_THRESHOLD, data);
      data = CsrDataW'($urandom);
      data[ReadW-1:0] = ReadW'(thr_float);
      csr_put(CSR_FLOAT_THRESHOLD, data);
      csr_put(CSR_CALIB_TIMEOUT, CsrDataW'(timeout_len));
      csr_valid <= 1'b0;
      settings_used++;
      @(posedge clock);
   endtask

   function automatic logic [ReadW-1:0] wobble(input int center);
      int v;
      v = center + $urandom_range(0, 6) - 3;
      if (v < 0)
         v = 0;
      if (v > ReadFull)
         v = ReadFull;
      return ReadW'(v);
   endfunction

   // Mostly plausible traffic: samples around slowly jumping knobs, steps that
   // walk the servo, gate requests, the odd init, and some raw noise.
   task automatic random_run(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 6) == 0)
               knob_open = $urandom_range(0, ReadFull);
            if ($urandom_range(0, 6) == 0)
               knob_closed = $urandom_range(0, ReadFull);
            put_item(ACT_SAMPLE, wobble(knob_open), wobble(knob_closed));
         end else if (pick < 70) begin
            put_item(ACT_STEP, ReadW'($urandom), ReadW'($urandom));
         end else if (pick < 80) begin
            put_item(ACT_OPEN, ReadW'($urandom), ReadW'($urandom));
         end else if (pick < 90) begin
            put_item(ACT_CLOSE, ReadW'($urandom), ReadW'($urandom));
         end else if (pick < 94) begin
            put_item(ACT_INIT, ReadW'(knob_open), ReadW'(knob_closed));
         end else begin
            put_item(ActionW'($urandom), ReadW'($urandom), ReadW'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset register values.
      put_item(ACT_STEP, 0, 0);            // step while already at target
      put_item(ACT_OPEN, 1023, 1023);
      put_item(ACT_OPEN, 0, 0);            // already open: ignored
      put_item(ACT_CLOSE, 0, 0);
      put_item(ACT_INIT, 1023, 0);
      put_item(ACT_SAMPLE, 1023, 0);       // same readings: no movement
      put_item(ACT_INIT, 0, 1023);         // full-scale closed angle
      put_item(ACT_OPEN, 512, 512);        // retarget to zero
      put_item(ACT_STEP, 0, 0);
      put_item(ACT_STEP, 0, 0);
      put_item(ACT_SAMPLE, 17, 1023);      // open jump right at begin threshold
      put_item(ACT_SAMPLE, 22, 1023);      // float-threshold move
      put_item(ACT_SAMPLE, 26, 0);         // small move, closed pot not looked at
      put_item(ACT_CLOSE, 0, 0);           // no retarget while calibrating
      put_item(ACT_OPEN, 0, 0);
      for (int k = 1; k <= 3; k++)
         put_item(ACT_INIT + ActionW'(k), 1023, 1023);   // unused codes
      put_item(ACT_INIT, 0, 0);
      put_item(ACT_SAMPLE, 0, 16);         // just under begin threshold
      put_item(ACT_SAMPLE, 0, 17);         // closed pot enters calibration
      put_item(ACT_SAMPLE, 40, 17);        // only the closed pot is checked
      put_item(ACT_INIT, 1023, 1023);
      put_item(ACT_SAMPLE, 0, 0);          // open wins, closed not checked
      drain();

      // Zero begin threshold, widest float, zero timeout.
      set_regs(0, 1023, 0);
      put_item(ACT_INIT, 500, 500);
      put_item(ACT_SAMPLE, 500, 500);      // zero difference still enters
      put_item(ACT_SAMPLE, 500, 9);        // first quiet sample ends it
      send_idles = 1'b1;
      take_idles = 1'b1;
      random_run(45);
      drain();

      // Widest begin threshold, zero float, longest timeout.
      set_regs(1023, 0, 65535);
      put_item(ACT_INIT, 0, 0);
      put_item(ACT_SAMPLE, 1023, 0);       // only a full-scale jump enters
      put_item(ACT_SAMPLE, 1023, 1023);    // zero float: every sample moves
      put_item(ACT_OPEN, 0, 0);
      put_item(ACT_STEP, 0, 0);
      random_run(45);
      drain();

      // Moderate random settings with short timeouts so calibrations finish.
      set_regs($urandom_range(8, 60), $urandom_range(2, 10), $urandom_range(2, 8));
      random_run(70);
      // Long receiver hold-off with the sender pushing back to back.
      send_idles = 1'b0;
      hold_go = 1'b1;
      random_run(30);
      send_idles = 1'b1;
      random_run(70);
      drain();

      set_regs($urandom_range(3, 40), $urandom_range(1, 8), $urandom_range(1, 12));
      random_run(160);
      drain();

      // Back to reset values; no idling for the last stretch.
      set_regs(BeginReset, FloatReset, TimeoutReset);
      send_idles = 1'b0;
      take_idles = 1'b0;
      random_run(160);
      drain();
      repeat (4) @(posedge clock);

      $display("Sent %0d beats over %0d register settings, checked %0d results.",
               beats_sent, settings_used + 1, checked_count);
      $display("Saw %0d calibration moves and %0d calibration timeouts.",
               move_count, done_count);
      if (fail_count == 0)
         $display("servo_gate_pot_calibrator verification clean");
      else
         $display("servo_gate_pot_calibrator verification failed");
      $finish;
   end

endmodule
